// ----- rtl/core/slma_pkg.sv -----
// package for the spike limited moving average unit
// request types, queue sizing and constants shared by front, back and top
package slma_pkg;

  localparam int unsigned ChW        = 3;
  localparam int unsigned SmpW       = 16;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = 2;
  localparam int unsigned QCntW      = 3;

  localparam logic signed [SmpW-1:0] SatMax = 16'sd32767;

  typedef struct packed {
    logic [ChW-1:0]         channel;
    logic signed [SmpW-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [ChW-1:0]         out_channel;
    logic signed [SmpW-1:0] filtered;
    logic                   limited;
    logic                   window_full;
  } out_t;

  typedef struct packed {
    logic                   in_range;
    logic [ChW-1:0]         channel;
    logic signed [SmpW-1:0] sample;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

// ----- rtl/core/slma_front.sv -----
// front end: accepts requests, tags channel range, holds them in a short queue
// depends on slma_pkg
module slma_front #(
  parameter int unsigned CHANNELS = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  slma_pkg::in_t  in_data_i,
  input  logic           pop_i,
  output slma_pkg::head_t head_o
);

  slma_pkg::item_t                 q_mem [slma_pkg::QueueDepth];
  logic [slma_pkg::QPtrW-1:0]      wr_q;
  logic [slma_pkg::QPtrW-1:0]      rd_q;
  logic [slma_pkg::QCntW-1:0]      cnt_q;
  logic                            push;
  slma_pkg::item_t                 cls;

  assign in_stall_o = (cnt_q == slma_pkg::QCntW'(slma_pkg::QueueDepth));
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    cls.in_range = (32'(in_data_i.channel) < CHANNELS);
    cls.channel  = in_data_i.channel;
    cls.sample   = in_data_i.sample;
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/core/slma_back.sv -----
// back end: per-channel ring update, spike clamp, running sum and average
// depends on slma_pkg; holds the sample ring memory
module slma_back #(
  parameter int unsigned WINDOW_LEN = 8,
  parameter int unsigned CHANNELS   = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  slma_pkg::head_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output slma_pkg::out_t  out_data_o
);

  localparam int unsigned PosW    = $clog2(WINDOW_LEN);
  localparam int unsigned ChIdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned Depth   = CHANNELS * WINDOW_LEN;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned SumW    = slma_pkg::SmpW + PosW;
  localparam int unsigned RecipW  = SumW + 1;
  localparam int unsigned Shift   = SumW + PosW;
  localparam int unsigned ProdW   = SumW + RecipW;
  localparam int unsigned QW      = slma_pkg::SmpW + 1;
  localparam logic [63:0] RecipWide =
    ((64'd1 << Shift) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipWide);

  localparam int unsigned SW = slma_pkg::SmpW;
  localparam int unsigned CW = slma_pkg::ChW;

  logic adv;

  // channel state
  logic [PosW-1:0]        pos_q    [CHANNELS];
  logic                   filled_q [CHANNELS];
  logic signed [SumW-1:0] sum_q    [CHANNELS];
  logic signed [SW-1:0]   ring_mem [Depth];

  // issue stage
  logic [ChIdxW-1:0] a_ch;
  logic [PosW-1:0]   a_pos;
  logic [AddrW-1:0]  a_addr;
  logic              a_go;

  // update stage
  logic                 b_valid_q;
  slma_pkg::item_t      b_item_q;
  logic                 b_full_q;
  logic [AddrW-1:0]     b_addr_q;
  logic signed [SW-1:0] rdata_q;
  logic [ChIdxW-1:0]    b_ch;
  logic signed [SW-1:0] b_old;
  logic [SW:0]          b_old_ext;
  logic [SW:0]          b_old_mag;
  logic [SW:0]          b_smp_ext;
  logic [SW:0]          b_smp_mag;
  logic [SW+1:0]        b_bound;
  logic                 b_lim;
  logic signed [SW-1:0] b_s_new;
  logic signed [SumW-1:0] b_sum;
  logic signed [SumW-1:0] b_new_sum;
  logic                 b_go;

  // multiply stage
  logic                   c_valid_q;
  logic [CW-1:0]          c_ch_q;
  logic                   c_in_range_q;
  logic                   c_full_q;
  logic                   c_lim_q;
  logic signed [SW-1:0]   c_echo_q;
  logic signed [SumW-1:0] c_sum_q;
  logic                   c_neg;
  logic [SumW-1:0]        c_mag;
  logic [ProdW-1:0]       c_prod;

  // scale stage
  logic                 d_valid_q;
  logic [CW-1:0]        d_ch_q;
  logic                 d_in_range_q;
  logic                 d_full_q;
  logic                 d_lim_q;
  logic signed [SW-1:0] d_echo_q;
  logic                 d_neg_q;
  logic [ProdW-1:0]     d_prod_q;
  logic [QW-1:0]        d_quo;
  logic [QW-1:0]        d_avg;
  slma_pkg::out_t       o_d;

  // output register
  logic           o_valid_q;
  slma_pkg::out_t o_q;

  assign adv   = !o_valid_q || !out_stall_i;
  assign pop_o = adv && head_i.valid;

  assign a_ch   = ChIdxW'(head_i.item.channel);
  assign a_go   = adv && head_i.valid && head_i.item.in_range;
  assign a_pos  = head_i.item.in_range ? pos_q[a_ch] : '0;
  assign a_addr = head_i.item.in_range ?
                  AddrW'(32'(a_ch) * WINDOW_LEN + 32'(a_pos)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_q[i]    <= '0;
        filled_q[i] <= 1'b0;
      end
    end else if (a_go) begin
      if (a_pos == PosW'(WINDOW_LEN - 1)) begin
        pos_q[a_ch]    <= '0;
        filled_q[a_ch] <= 1'b1;
      end else begin
        pos_q[a_ch] <= a_pos + 1'b1;
      end
    end
  end

  // ring memory: write in update stage, registered read in issue stage
  always_ff @(posedge clk_i) begin
    if (b_go) begin
      ring_mem[b_addr_q] <= b_s_new;
    end
    if (adv) begin
      rdata_q <= ring_mem[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_item_q <= head_i.item;
      b_full_q <= head_i.item.in_range && filled_q[a_ch];
      b_addr_q <= a_addr;
    end
  end

  // old entry reads as zero until the window has wrapped once
  assign b_ch      = ChIdxW'(b_item_q.channel);
  assign b_go      = adv && b_valid_q && b_item_q.in_range;
  assign b_old     = b_full_q ? rdata_q : '0;
  assign b_old_ext = {b_old[SW-1], b_old};
  assign b_old_mag = b_old[SW-1] ? ((SW+1)'(0) - b_old_ext) : b_old_ext;
  assign b_smp_ext = {b_item_q.sample[SW-1], b_item_q.sample};
  assign b_smp_mag = b_item_q.sample[SW-1] ? ((SW+1)'(0) - b_smp_ext) : b_smp_ext;
  assign b_bound   = {b_old_mag, 1'b0};
  assign b_lim     = b_full_q && ({1'b0, b_smp_mag} > b_bound);

  always_comb begin
    if (!b_lim) begin
      b_s_new = b_item_q.sample;
    end else if (b_bound > (SW+2)'(slma_pkg::SatMax)) begin
      b_s_new = slma_pkg::SatMax;
    end else begin
      b_s_new = SW'(b_bound);
    end
  end

  assign b_sum     = b_item_q.in_range ? sum_q[b_ch] : '0;
  assign b_new_sum = b_sum - {{(SumW-SW){b_old[SW-1]}}, b_old}
                           + {{(SumW-SW){b_s_new[SW-1]}}, b_s_new};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i] <= '0;
      end
    end else if (b_go) begin
      sum_q[b_ch] <= b_new_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_ch_q       <= b_item_q.channel;
      c_in_range_q <= b_item_q.in_range;
      c_full_q     <= b_full_q;
      c_lim_q      <= b_lim;
      c_echo_q     <= b_s_new;
      c_sum_q      <= b_new_sum;
    end
  end

  // truncating divide by the window length via reciprocal multiply
  assign c_neg  = c_sum_q[SumW-1];
  assign c_mag  = c_neg ? (SumW'(0) - c_sum_q) : c_sum_q;
  assign c_prod = ProdW'(c_mag) * ProdW'(Recip);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_ch_q       <= c_ch_q;
      d_in_range_q <= c_in_range_q;
      d_full_q     <= c_full_q;
      d_lim_q      <= c_lim_q;
      d_echo_q     <= c_echo_q;
      d_neg_q      <= c_neg;
      d_prod_q     <= c_prod;
    end
  end

  assign d_quo = d_prod_q[Shift +: QW];
  assign d_avg = d_neg_q ? (QW'(0) - d_quo) : d_quo;

  always_comb begin
    o_d.out_channel = d_ch_q;
    o_d.limited     = d_in_range_q && d_lim_q;
    o_d.window_full = d_in_range_q && d_full_q;
    if (!d_in_range_q) begin
      o_d.filtered = '0;
    end else if (d_full_q) begin
      o_d.filtered = SW'(d_avg);
    end else begin
      o_d.filtered = d_echo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_q <= o_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= head_i.valid;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      o_valid_q <= d_valid_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_q;

  a_pop_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> b_valid_q)
    else $error("popped request missing from update stage");

  a_clamp_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_lim |-> !b_s_new[SW-1])
    else $error("clamped sample is negative");

  a_limit_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && o_q.limited |-> o_q.window_full)
    else $error("spike clamp reported outside a full window");

endmodule

// ----- rtl/core/spike_limited_moving_average_unit.sv -----
// top level of the spike limited moving average unit
// depends on slma_pkg, slma_front and slma_back
//
//   port group   dir   handshake                  payload
//   in_*         in    in_valid_i / in_stall_o    slma_pkg::in_t  (channel, sample)
//   out_*        out   out_valid_o / out_stall_i  slma_pkg::out_t (result fields)
//
// one request per cycle sustained while out_stall_i does not hold the back pipeline; after it
// leaves the queue each request passes the back pipeline (issue, ring update, multiply, scale)
// the rate is set by the per-channel ring read-modify-write: read in one stage,
// written with the running sum in the next
// reset clears queue, pipeline valids, write positions, fill flags and sums
// out_stall_i freezes the back pipeline; the four-entry queue keeps taking
// requests until it fills, then in_stall_o rises
module spike_limited_moving_average_unit #(
  parameter int unsigned WINDOW_LEN = 8,
  parameter int unsigned CHANNELS   = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  slma_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output slma_pkg::out_t out_data_o
);

  slma_pkg::head_t head;
  logic            pop;

  slma_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  slma_back #(
    .WINDOW_LEN (WINDOW_LEN),
    .CHANNELS   (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
